>>> hdl/tfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared constants and controller/datapath interface types for the
// transfer function rasterizer.
// ----------------------------------------------------------------------------
package tfr_pkg;

    // Table geometry.
    localparam int MAX_TEXELS = 256;
    localparam int IDX_W      = $clog2(MAX_TEXELS);
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int COL_W      = CH_W * NUM_CH;
    localparam int POS_W      = 16;
    localparam int TEX_CNT_W  = 9;

    // Stream payload widths.
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = COL_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXELS_IN_USE = 2'd2;

    // Operation codes carried in tuser.
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;    // latch an accepted transaction
        logic       mul;        // form offset product, load the divider
        logic       div_step;   // one restoring division step
        logic       idx_save;   // keep the quotient as the point index
        logic       ch_load;    // load the divider with one channel delta
        logic [1:0] ch;         // channel being worked on
        logic       ch_save;    // keep channel step and remainder step
        logic       fill_init;  // start the segment fill
        logic       fill_step;  // write one blended texel
        logic       own_write;  // write the point's own texel
        logic       out_load;   // load the read result into the output
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_read;          // accepted transaction is a read
        logic need_blend;       // segment to blend exists
        logic fill_last;        // current fill texel is the last one
    } t_status;

endpackage

>>> hdl/tfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/tfr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_datapath
// Configuration registers, index mapping, shared restoring divider,
// incremental channel blender, texel store with valid bits, output data.
// ----------------------------------------------------------------------------
module tfr_datapath
    import tfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_user,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    // Configuration.
    logic [POS_W-1:0]     r_vmin, r_vmax;
    logic [TEX_CNT_W-1:0] r_texels;

    // Captured transaction.
    logic [POS_W-1:0] r_pos;
    logic [COL_W-1:0] r_col;
    logic [IDX_W-1:0] r_rd_idx;

    // Divider.
    logic [POS_W-1:0] r_rem, r_dsr;
    logic [7:0]       r_quo;
    logic             r_dneg;

    // Segment and blending state.
    logic [IDX_W-1:0] r_idx, r_n, r_addr, r_prev_idx;
    logic [COL_W-1:0] r_prev_col;
    logic             r_have_prev;
    logic [CH_W-1:0]  r_dq [NUM_CH];
    logic [CH_W-1:0]  r_dr [NUM_CH];
    logic [CH_W-1:0]  r_q  [NUM_CH];
    logic [CH_W-1:0]  r_r  [NUM_CH];
    logic [MAX_TEXELS-1:0] r_valid;
    logic [OUT_DATA_W-1:0] r_out;

    // Combinational helpers.
    logic [POS_W-1:0]     x_clamp, off, range_w;
    logic [TEX_CNT_W-1:0] t_eff;
    logic [IDX_W-1:0]     tm1;
    logic [23:0]          prod;
    logic                 zero_range;
    logic [POS_W:0]       div_t;
    logic                 div_ge;
    logic [CH_W-1:0]      ch_a, ch_b, ch_mag;
    logic [CH_W:0]        ch_delta;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [COL_W-1:0]     ram_wdata, ram_rdata, fill_col;

    // Index mapping: clamp, offset and scale by the texel count less one.
    always_comb begin
        zero_range = (r_vmax <= r_vmin);
        x_clamp = r_pos;
        if (x_clamp < r_vmin) x_clamp = r_vmin;
        if (x_clamp > r_vmax) x_clamp = r_vmax;
        off     = x_clamp - r_vmin;
        range_w = r_vmax - r_vmin;
        t_eff   = r_texels;
        if (t_eff < TEX_CNT_W'(2)) t_eff = TEX_CNT_W'(2);
        if (t_eff > TEX_CNT_W'(MAX_TEXELS)) t_eff = TEX_CNT_W'(MAX_TEXELS);
        tm1  = IDX_W'(t_eff - TEX_CNT_W'(1));
        prod = 24'(off) * 24'(tm1);
    end

    // Restoring division step shared by index and channel work.
    assign div_t  = {r_rem, r_quo[7]};
    assign div_ge = (div_t >= {1'b0, r_dsr});

    // Channel delta for the channel selected by the controller.
    always_comb begin
        ch_a     = r_prev_col[i_cmd.ch*CH_W +: CH_W];
        ch_b     = r_col[i_cmd.ch*CH_W +: CH_W];
        ch_delta = {1'b0, ch_b} - {1'b0, ch_a};
        ch_mag   = ch_delta[CH_W] ? CH_W'(-ch_delta) : ch_delta[CH_W-1:0];
    end

    // Packed current blend value.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            fill_col[c*CH_W +: CH_W] = r_q[c];
        end
    end

    // Texel store write port.
    always_comb begin
        ram_we    = i_cmd.fill_step | i_cmd.own_write;
        ram_waddr = i_cmd.own_write ? r_idx : r_addr;
        ram_wdata = i_cmd.own_write ? r_col : fill_col;
    end

    tfr_ram #(.WIDTH(COL_W), .DEPTH(MAX_TEXELS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // Control state: configuration, valid bits, previous point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmin      <= '0;
            r_vmax      <= POS_W'(1);
            r_texels    <= TEX_CNT_W'(MAX_TEXELS);
            r_valid     <= '0;
            r_have_prev <= 1'b0;
            r_prev_idx  <= '0;
            r_prev_col  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VALUE_MIN:     r_vmin   <= i_cfg_data;
                    CFG_VALUE_MAX:     r_vmax   <= i_cfg_data;
                    CFG_TEXELS_IN_USE: r_texels <= i_cfg_data[TEX_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.capture && (i_in_user == OP_POINT) && i_in_data[0]) begin
                r_valid     <= '0;
                r_have_prev <= 1'b0;
            end
            if (i_cmd.fill_step) r_valid[r_addr] <= 1'b1;
            if (i_cmd.own_write) begin
                r_valid[r_idx] <= 1'b1;
                r_have_prev    <= 1'b1;
                r_prev_idx     <= r_idx;
                r_prev_col     <= r_col;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos    <= i_in_data[16:1];
            r_col    <= i_in_data[48:17];
            r_rd_idx <= i_in_data[56:49];
        end
        if (i_cmd.mul) begin
            r_rem <= zero_range ? '0 : prod[23:8];
            r_quo <= zero_range ? '0 : prod[7:0];
            r_dsr <= zero_range ? POS_W'(1) : range_w;
        end
        if (i_cmd.ch_load) begin
            r_rem  <= '0;
            r_quo  <= ch_mag;
            r_dsr  <= POS_W'(r_n);
            r_dneg <= ch_delta[CH_W];
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? POS_W'(div_t - {1'b0, r_dsr}) : div_t[POS_W-1:0];
            r_quo <= {r_quo[6:0], div_ge};
        end
        if (i_cmd.idx_save) begin
            r_idx <= r_quo;
            r_n   <= r_quo - r_prev_idx;
        end
        // Floor division of the signed delta by the segment length.
        if (i_cmd.ch_save) begin
            if (!r_dneg || (r_rem == '0)) begin
                r_dq[i_cmd.ch] <= r_dneg ? CH_W'(-r_quo) : r_quo;
                r_dr[i_cmd.ch] <= r_dneg ? '0 : r_rem[CH_W-1:0];
            end else begin
                r_dq[i_cmd.ch] <= CH_W'(-r_quo) - CH_W'(1);
                r_dr[i_cmd.ch] <= r_n - r_rem[CH_W-1:0];
            end
        end
        if (i_cmd.fill_init) begin
            r_addr <= r_prev_idx;
            for (int c = 0; c < NUM_CH; c++) begin
                r_q[c] <= r_prev_col[c*CH_W +: CH_W];
                r_r[c] <= r_n >> 1;
            end
        end
        // Incremental blend: quotient and remainder advance by one step.
        if (i_cmd.fill_step) begin
            r_addr <= r_addr + IDX_W'(1);
            for (int c = 0; c < NUM_CH; c++) begin
                if (({1'b0, r_r[c]} + {1'b0, r_dr[c]}) >= {1'b0, r_n}) begin
                    r_r[c] <= r_r[c] + r_dr[c] - r_n;
                    r_q[c] <= r_q[c] + r_dq[c] + CH_W'(1);
                end else begin
                    r_r[c] <= r_r[c] + r_dr[c];
                    r_q[c] <= r_q[c] + r_dq[c];
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_valid[r_rd_idx] ? ram_rdata : '0;
        end
    end

    assign o_status.in_read    = (i_in_user == OP_READ);
    assign o_status.need_blend = r_have_prev && (r_quo > r_prev_idx);
    assign o_status.fill_last  = (r_addr == (r_idx - IDX_W'(1)));
    assign o_out_data          = r_out;

endmodule

>>> hdl/tfr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfr_ctrl
// Sequencer for reads, index division, channel step division, segment fill
// and the point's own texel write; owns the stream handshakes.
// ----------------------------------------------------------------------------
module tfr_ctrl
    import tfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RADDR = 4'd1;
    localparam logic [3:0] S_ROUT  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_IDX   = 4'd5;
    localparam logic [3:0] S_CLOAD = 4'd6;
    localparam logic [3:0] S_CDIV  = 4'd7;
    localparam logic [3:0] S_CSAVE = 4'd8;
    localparam logic [3:0] S_FINIT = 4'd9;
    localparam logic [3:0] S_FILL  = 4'd10;
    localparam logic [3:0] S_OWN   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_ch, n_ch;
    logic       r_out_valid, n_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ch        = r_ch;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_cmd.ch    = r_ch;
        o_in_ready  = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_status.in_read ? S_RADDR : S_MUL;
                end
            end
            S_RADDR: n_state = S_ROUT;
            S_ROUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) n_state = S_IDX;
            end
            S_IDX: begin
                o_cmd.idx_save = 1'b1;
                n_ch    = '0;
                n_state = i_status.need_blend ? S_CLOAD : S_OWN;
            end
            S_CLOAD: begin
                o_cmd.ch_load = 1'b1;
                n_cnt   = '0;
                n_state = S_CDIV;
            end
            S_CDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) n_state = S_CSAVE;
            end
            S_CSAVE: begin
                o_cmd.ch_save = 1'b1;
                n_ch    = r_ch + 2'd1;
                n_state = (r_ch == 2'd3) ? S_FINIT : S_CLOAD;
            end
            S_FINIT: begin
                o_cmd.fill_init = 1'b1;
                n_state = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) n_state = S_OWN;
            end
            S_OWN: begin
                o_cmd.own_write = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> hdl/transfer_function_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transfer_function_rasterizer
// Builds a 256-texel color and opacity lookup table from control points
// and serves single-texel reads.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one transaction per accepted beat; tuser selects
//   a control point (0) or a texel read (1). Points produce no output; each
//   read produces one transaction on the master stream.
//   Configuration registers are written through the plain write port; the user must
//   write them only while the block is idle, which the block does not enforce.
// Timing:
//   A read passes the read-address state and then loads the output register,
//   waiting while an earlier result is still held, before the block returns
//   to idle. A point runs index mapping (one multiply, eight divider steps,
//   index save) and then its own texel write; when it extends a segment of n
//   texels, the four per-channel step divisions, the fill set-up and a fill of
//   n texels come between, one texel per cycle through the single store write
//   port.
// Reset and stall:
//   Reset clears the table (valid bits), the previous point and the
//   configuration registers to their defaults. A stalled result holds in
//   the output register while the block accepts and processes further
//   points; a second read waits until the output register is free.
// ----------------------------------------------------------------------------
module transfer_function_rasterizer
    import tfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // restart[0], point_position[16:1], point_red[24:17], point_green[32:25],
    // point_blue[40:33], point_opacity[48:41], read_index[56:49], zeros above.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[0].
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // texel_red[7:0], texel_green[15:8], texel_blue[23:16],
    // texel_opacity[31:24].
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Sequencer.
    tfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath and texel store.
    tfr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (m_axis_tdata)
    );

endmodule
